// ===== design/cone_match_first_jet_unit_assert.svh =====
// -----------------------------------------------------------------------------
// Cone match assertion macros
// Concurrent assertion wrappers for the cone match unit; empty in synthesis.
// -----------------------------------------------------------------------------
`ifndef CONE_MATCH_FIRST_JET_UNIT_ASSERT_SVH
`define CONE_MATCH_FIRST_JET_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// check prop at every rising edge outside reset
`define CMFJ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check prop at every rising edge, reset included
`define CMFJ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CMFJ_ASSERT(lbl, clk, rst_n, prop, msg)
`define CMFJ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/cmfj_pkg.sv =====
// -----------------------------------------------------------------------------
// Cone match package
// Shared widths, codes and types of the cone match unit.
// -----------------------------------------------------------------------------
`default_nettype none
package cmfj_pkg;

  localparam int MAX_JETS = 64;
  localparam int CNT_W    = $clog2(MAX_JETS + 1);
  localparam int IDX_W    = $clog2(MAX_JETS);

  localparam int ETA_W    = 12;
  localparam int PHI_W    = 11;
  localparam int MATCH_W  = 7;
  localparam int RADIUS_W = 24;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;

  localparam logic [RADIUS_W-1:0] RADIUS_SQ_RESET = 24'd10486;

  // pi and 2 pi in Q3.8
  localparam logic signed [PHI_W-1:0] PI_Q     = 11'sd804;
  localparam logic        [PHI_W-1:0] TWO_PI_Q = 11'd1608;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_JET   = 2'd1,
    FUNC_CLOSE = 2'd2
  } func_t;

  typedef struct packed {
    logic signed [ETA_W-1:0] eta;
    logic signed [PHI_W-1:0] phi;
  } point_t;

endpackage
`default_nettype wire

// ===== design/cmfj_cone_test.sv =====
// -----------------------------------------------------------------------------
// Cone test
// Tells whether a jet lies inside the squared cone radius around a reference.
// -----------------------------------------------------------------------------
`default_nettype none
module cmfj_cone_test (
  input  wire  cmfj_pkg::point_t                  ref_pt,
  input  wire  cmfj_pkg::point_t                  jet_pt,
  input  wire  logic [cmfj_pkg::RADIUS_W-1:0]     radius_sq,
  output logic                                    hit
);
  import cmfj_pkg::*;

  logic signed [ETA_W:0]   d_eta;
  logic        [ETA_W-1:0] a_eta;
  logic signed [PHI_W:0]   d_phi;
  logic        [PHI_W-1:0] a_phi;
  logic        [PHI_W-2:0] w_phi;
  logic        [2*ETA_W-1:0]     sq_eta;
  logic        [2*(PHI_W-1)-1:0] sq_phi;
  logic        [2*ETA_W:0]       dist_sq;

  always_comb begin
    d_eta = {ref_pt.eta[ETA_W-1], ref_pt.eta} - {jet_pt.eta[ETA_W-1], jet_pt.eta};
    d_phi = {ref_pt.phi[PHI_W-1], ref_pt.phi} - {jet_pt.phi[PHI_W-1], jet_pt.phi};
    a_eta = d_eta[ETA_W] ? ETA_W'(-d_eta) : d_eta[ETA_W-1:0];
    a_phi = d_phi[PHI_W] ? PHI_W'(-d_phi) : d_phi[PHI_W-1:0];
    // wrap around the circle: the short way is at most pi
    if (a_phi >= PHI_W'(PI_Q)) begin
      w_phi = (PHI_W-1)'(TWO_PI_Q - a_phi);
    end else begin
      w_phi = a_phi[PHI_W-2:0];
    end
    sq_eta  = a_eta * a_eta;
    sq_phi  = w_phi * w_phi;
    dist_sq = {1'b0, sq_eta} + (2*ETA_W+1)'(sq_phi);
    hit     = dist_sq <= (2*ETA_W+1)'(radius_sq);
  end

endmodule
`default_nettype wire

// ===== design/cone_match_first_jet_unit.sv =====
// -----------------------------------------------------------------------------
// Cone match first jet unit
// Delta-R matching of a jet stream against two per-event reference points.
// -----------------------------------------------------------------------------
// The unit takes one word per cycle on its input stream. A word whose tuser
// says load writes one of two reference points (eta, phi, present flag); a
// jet word is tested against both present references that have no match yet
// and is numbered in arrival order; a close word emits one output word with
// the index of the first jet inside each reference cone (-1 when none) and
// the jet count, then clears the event. Jets past the maximum count are
// dropped, and tuser code 3 is dropped. Every word passes through the
// input register, and a new word is taken in every cycle; the only stall
// is a close word while the output register still holds an earlier result
// that has not been taken. An accepted close word moves from the input
// register to the output register, which raises out_tvalid. The cone
// radius (squared, Q.16) is written through the cfg port, which is always
// ready, and must be written only while the unit is idle.
// -----------------------------------------------------------------------------
`default_nettype none
`include "cone_match_first_jet_unit_assert.svh"
module cone_match_first_jet_unit (
  input  wire  logic                                 clk,
  input  wire  logic                                 rst_n,
  // input stream
  input  wire  logic                                 in_tvalid,
  output logic                                       in_tready,
  // [0] ref_slot, [1] ref_valid, [13:2] eta, [24:14] phi, [31:25] zero
  input  wire  logic [cmfj_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [1:0] func
  input  wire  logic [cmfj_pkg::IN_TUSER_W-1:0]      in_tuser,
  // result stream
  output logic                                       out_tvalid,
  input  wire  logic                                 out_tready,
  // [6:0] match_first, [13:7] match_second, [20:14] event_jets, [23:21] zero
  output logic [cmfj_pkg::OUT_TDATA_W-1:0]           out_tdata,
  // configuration
  input  wire  logic                                 cfg_valid,
  output logic                                       cfg_ready,
  input  wire  logic [cmfj_pkg::RADIUS_W-1:0]        cfg_data
);
  import cmfj_pkg::*;

  function automatic logic signed [PHI_W-1:0] sat_phi(input logic signed [PHI_W-1:0] p);
    if (p > PI_Q) begin
      return PI_Q;
    end else if (p < -PI_Q) begin
      return -PI_Q;
    end
    return p;
  endfunction

  // input register
  logic    s1_valid_r;
  func_t   s1_func_r;
  logic    s1_slot_r;
  logic    s1_refv_r;
  point_t  s1_pt_r;
  logic    s1_go;
  logic    in_take;

  // event state
  logic [RADIUS_W-1:0] radius_r;
  point_t              ref_pt_r [2];
  logic [1:0]          ref_on_r, ref_on_nxt;
  logic [1:0]          found_r, found_nxt;
  logic [IDX_W-1:0]    found_idx_r [2];
  logic [CNT_W-1:0]    jet_count_r, jet_count_nxt;
  logic [1:0]          hit;
  logic                jet_room;

  // output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [MATCH_W-1:0]     match_nxt [2];

  // a close word needs a free output register; all other words always finish
  assign s1_go     = s1_valid_r &&
                     ((s1_func_r != FUNC_CLOSE) || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_take   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // capture the word, saturating phi on the way in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_take) begin
      s1_func_r   <= func_t'(in_tuser[1:0]);
      s1_slot_r   <= in_tdata[0];
      s1_refv_r   <= in_tdata[1];
      s1_pt_r.eta <= in_tdata[13:2];
      s1_pt_r.phi <= sat_phi(in_tdata[24:14]);
    end
  end

  cmfj_cone_test u_test0 (
    .ref_pt    (ref_pt_r[0]),
    .jet_pt    (s1_pt_r),
    .radius_sq (radius_r),
    .hit       (hit[0])
  );

  cmfj_cone_test u_test1 (
    .ref_pt    (ref_pt_r[1]),
    .jet_pt    (s1_pt_r),
    .radius_sq (radius_r),
    .hit       (hit[1])
  );

  assign jet_room = jet_count_r < CNT_W'(MAX_JETS);

  always_comb begin
    ref_on_nxt    = ref_on_r;
    found_nxt     = found_r;
    jet_count_nxt = jet_count_r;
    for (int s = 0; s < 2; s++) begin
      // report -1 (all ones) when the slot is absent or never matched
      if (ref_on_r[s] && found_r[s]) begin
        match_nxt[s] = MATCH_W'(found_idx_r[s]);
      end else begin
        match_nxt[s] = '1;
      end
    end
    if (s1_go) begin
      case (s1_func_r)
        FUNC_LOAD: begin
          ref_on_nxt[s1_slot_r] = s1_refv_r;
        end
        FUNC_JET: begin
          if (jet_room) begin
            found_nxt     = found_r | (ref_on_r & ~found_r & hit);
            jet_count_nxt = jet_count_r + CNT_W'(1);
          end
        end
        FUNC_CLOSE: begin
          ref_on_nxt    = '0;
          found_nxt     = '0;
          jet_count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= RADIUS_SQ_RESET;
      ref_on_r    <= '0;
      found_r     <= '0;
      jet_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        radius_r <= cfg_data;
      end
      ref_on_r    <= ref_on_nxt;
      found_r     <= found_nxt;
      jet_count_r <= jet_count_nxt;
      // hold the result until taken, load a new one on close
      if (s1_go && (s1_func_r == FUNC_CLOSE)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload of the event state and the output word
  always_ff @(posedge clk) begin
    if (s1_go && (s1_func_r == FUNC_LOAD)) begin
      ref_pt_r[s1_slot_r] <= s1_pt_r;
    end
    for (int s = 0; s < 2; s++) begin
      if (s1_go && (s1_func_r == FUNC_JET) && jet_room && !found_r[s] && found_nxt[s]) begin
        found_idx_r[s] <= jet_count_r[IDX_W-1:0];
      end
    end
    if (s1_go && (s1_func_r == FUNC_CLOSE)) begin
      out_data_r <= {(OUT_TDATA_W - 3*MATCH_W)'(0), MATCH_W'(jet_count_r),
                     match_nxt[1], match_nxt[0]};
    end
  end

  `CMFJ_ASSERT(a_count_bound, clk, rst_n, jet_count_r <= CNT_W'(MAX_JETS), "jet count past maximum")
  `CMFJ_ASSERT(a_idx_below_count, clk, rst_n, found_r[0] |-> ((CNT_W+1)'(found_idx_r[0]) < (CNT_W+1)'(jet_count_r)), "slot 0 index not below count")
  `CMFJ_ASSERT(a_close_clears, clk, rst_n, (s1_go && s1_func_r == FUNC_CLOSE) |=> (jet_count_r == '0 && found_r == 2'b00 && ref_on_r == 2'b00), "close did not clear event")
  `CMFJ_ASSERT(a_close_emits, clk, rst_n, (s1_go && s1_func_r == FUNC_CLOSE) |=> out_valid_r, "close without result")
  `CMFJ_ASSERT(a_stall_cause, clk, rst_n, !in_tready |-> (s1_valid_r && s1_func_r == FUNC_CLOSE && out_valid_r && !out_tready), "input stalled without blocked close")

endmodule
`default_nettype wire
